FILE: design/tce_pkg.sv
`timescale 1ns / 1ps

package tce_pkg;

    // Frame layout.
    localparam int ETH_HEADER_BYTES      = 14;
    localparam int IP_FIXED_HEADER_BYTES = 20;

    // Offsets and limits, sized to compare against a 17-bit byte position.
    localparam logic [16:0] ETH_BASE     = 17'(ETH_HEADER_BYTES);
    localparam logic [16:0] ICMP_BASE    = 17'(ETH_HEADER_BYTES + IP_FIXED_HEADER_BYTES);
    localparam logic [16:0] IP_LEN_HI    = 17'(ETH_HEADER_BYTES + 2);
    localparam logic [16:0] IP_LEN_LO    = 17'(ETH_HEADER_BYTES + 3);
    localparam logic [16:0] ADDR_FIRST   = 17'(ETH_HEADER_BYTES + 12);
    localparam logic [16:0] ADDR_END     = 17'(ETH_HEADER_BYTES + 20);
    localparam logic [16:0] ICMP_CKS_OFF = 17'(ETH_HEADER_BYTES + IP_FIXED_HEADER_BYTES + 2);
    localparam logic [16:0] ICMP_MIN_LEN = 17'(ETH_HEADER_BYTES + IP_FIXED_HEADER_BYTES + 4);
    localparam logic [15:0] INDEX_MAX    = 16'hFFFF;

    // Checksum field position within the transport header.
    localparam logic [4:0] TCP_CKS_REL = 5'd16;
    localparam logic [4:0] UDP_CKS_REL = 5'd6;

    // Minimum legal IPv4 header length, in 32-bit words.
    localparam logic [3:0] IHL_MIN = 4'd5;

    // Protocol numbers for the pseudo-header.
    localparam logic [15:0] PROTO_TCP = 16'h0006;
    localparam logic [15:0] PROTO_UDP = 16'h0011;

    // Frame mode codes.
    localparam logic [1:0] MODE_TCP  = 2'd0;
    localparam logic [1:0] MODE_UDP  = 2'd1;
    localparam logic [1:0] MODE_ICMP = 2'd2;

    // One finished result.
    typedef struct packed {
        logic [15:0] checksum;
        logic [15:0] checksum_offset;
        logic        frame_error;
    } t_result;

    // Ones'-complement add with end-around carry.
    function automatic logic [15:0] f_ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

FILE: design/transport_checksum_engine.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+--------------------------------------
// input     | in        | i_in_valid, o_in_stall | i_frame_byte, i_last_byte, i_mode
// result    | out       | o_out_valid, i_out_stall | o_checksum, o_checksum_offset,
//           |           |                        | o_frame_error
//
// One frame byte is accepted per clock while the input is not stalled; the rate is set
// by the single ones'-complement accumulate register, which takes one byte per cycle.
// The result of the last byte is registered in the output register, or in the skid
// register when the output is full and stalled. Reset is synchronous and active low;
// it clears the frame state and empties both result slots. The input stalls only
// while both slots are full.

module transport_checksum_engine
    import tce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    input  logic [1:0]  i_mode,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_checksum,
    output logic [15:0] o_checksum_offset,
    output logic        o_frame_error
);

    // Frame state.
    logic [15:0] r_byte_index, n_byte_index;
    logic [1:0]  r_frame_kind, n_frame_kind;
    logic [3:0]  r_header_words, n_header_words;
    logic [15:0] r_ip_total_length, n_ip_total_length;
    logic [15:0] r_sum, n_sum;

    // Result slots: the output register and the skid register behind it.
    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        accept;
    logic        pop;
    logic        push;
    t_result     new_result;

    // Values seen by the current byte, with the frame start clearing the old frame.
    logic        first;
    logic [3:0]  hw_cur;
    logic [15:0] itl_cur;
    logic [15:0] sum_cur;
    logic        transport;
    logic [16:0] pos;
    logic [5:0]  hl;
    logic [16:0] seg_start;
    logic [16:0] seg_end;
    logic [4:0]  cks_rel;
    logic [16:0] cks_off;
    logic        in_addr;
    logic        in_seg;
    logic        in_icmp;
    logic        odd_pos;
    logic [15:0] weight;
    logic [15:0] addend;
    logic [15:0] seglen;
    logic [15:0] pseudo;
    logic [15:0] final_sum;
    logic [16:0] n_count;
    logic        err;

    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid && !r_skid_valid;
    assign pop        = r_out_valid && !i_out_stall;
    assign push       = accept && i_last_byte;

    always_comb begin
        first   = (r_byte_index == 16'd0);
        n_frame_kind = first ? i_mode : r_frame_kind;
        hw_cur  = first ? 4'd0 : r_header_words;
        itl_cur = first ? 16'd0 : r_ip_total_length;
        sum_cur = first ? 16'd0 : r_sum;
        transport = (n_frame_kind == MODE_TCP) || (n_frame_kind == MODE_UDP);
        pos     = {1'b0, r_byte_index};

        // The IPv4 header length and total length are captured as they pass.
        n_header_words    = hw_cur;
        n_ip_total_length = itl_cur;
        if (transport) begin
            if (pos == ETH_BASE) begin
                n_header_words = i_frame_byte[3:0];
            end
            if (pos == IP_LEN_HI) begin
                n_ip_total_length = {i_frame_byte, itl_cur[7:0]};
            end
            if (pos == IP_LEN_LO) begin
                n_ip_total_length = {itl_cur[15:8], i_frame_byte};
            end
        end

        hl        = {n_header_words, 2'b00};
        seg_start = ETH_BASE + {11'd0, hl};
        seg_end   = ETH_BASE + {1'b0, n_ip_total_length};
        cks_rel   = (n_frame_kind == MODE_TCP) ? TCP_CKS_REL : UDP_CKS_REL;
        cks_off   = transport ? (seg_start + {12'd0, cks_rel}) : ICMP_CKS_OFF;

        // Source and destination addresses feed the pseudo-header; the segment
        // itself is summed with its checksum field skipped.
        in_addr = transport && (pos >= ADDR_FIRST) && (pos < ADDR_END);
        in_seg  = transport && (pos >= seg_start) && (pos < seg_end)
                  && (pos != cks_off) && (pos != cks_off + 17'd1);
        in_icmp = !transport && (pos >= ICMP_BASE)
                  && (pos != cks_off) && (pos != cks_off + 17'd1);

        odd_pos = transport ? (pos[0] ^ ETH_BASE[0]) : (pos[0] ^ ICMP_BASE[0]);
        weight  = odd_pos ? {8'h00, i_frame_byte} : {i_frame_byte, 8'h00};

        // With a short header the address bytes also fall inside the segment and
        // count twice; doubling in ones'-complement is a rotate left by one.
        if (r_byte_index == INDEX_MAX) begin
            addend = 16'd0;
        end else if (in_addr && in_seg) begin
            addend = {weight[14:0], weight[15]};
        end else if (in_addr || in_seg || in_icmp) begin
            addend = weight;
        end else begin
            addend = 16'd0;
        end
        n_sum = f_ones_add(sum_cur, addend);

        // Closing terms, used only on the last byte of a frame.
        seglen  = n_ip_total_length - {10'd0, hl};
        pseudo  = f_ones_add((n_frame_kind == MODE_TCP) ? PROTO_TCP : PROTO_UDP, seglen);
        n_count = pos + 17'd1;
        err     = (r_byte_index == INDEX_MAX);
        if (transport) begin
            final_sum = f_ones_add(n_sum, pseudo);
            if ((n_header_words < IHL_MIN) || (n_ip_total_length < {10'd0, hl})
                || (seglen < {11'd0, cks_rel} + 16'd2) || (n_count < seg_end)) begin
                err = 1'b1;
            end
        end else begin
            final_sum = n_sum;
            if ((n_frame_kind != MODE_ICMP) || (n_count < ICMP_MIN_LEN)) begin
                err = 1'b1;
            end
        end

        new_result.checksum        = ~final_sum;
        new_result.checksum_offset = cks_off[15:0];
        new_result.frame_error     = err;

        if (i_last_byte) begin
            n_byte_index = 16'd0;
        end else if (r_byte_index != INDEX_MAX) begin
            n_byte_index = r_byte_index + 16'd1;
        end else begin
            n_byte_index = r_byte_index;
        end
    end

    // Frame state advances on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index      <= 16'd0;
            r_frame_kind      <= MODE_TCP;
            r_header_words    <= 4'd0;
            r_ip_total_length <= 16'd0;
            r_sum             <= 16'd0;
        end else if (accept) begin
            r_byte_index      <= n_byte_index;
            r_frame_kind      <= n_frame_kind;
            r_header_words    <= n_header_words;
            r_ip_total_length <= n_ip_total_length;
            r_sum             <= n_sum;
        end
    end

    // Result slot control. A new result goes straight to the output register when
    // it is free or being emptied, and into the skid register otherwise.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out <= new_result;
            end else begin
                r_skid <= new_result;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_checksum        = r_out.checksum;
    assign o_checksum_offset = r_out.checksum_offset;
    assign o_frame_error     = r_out.frame_error;

endmodule

FILE: tb/tb_transport_checksum_engine.sv
`timescale 1ns / 1ps

// Self-checking bench for the transport checksum engine.
// Frames are fed one byte per transaction. A local model of the checksum logic follows
// every accepted byte, and each frame's result is queued when its last byte is accepted.
// The output monitor compares every result transaction against the oldest queued entry.
module tb_transport_checksum_engine;
    import tce_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_ITEMS    = 830;
    localparam int QUIET_ITEMS     = 250;
    localparam int PRESSURE_CYCLES = 600;
    localparam int DRAIN_CYCLES    = 20;
    localparam int DIRECTED_ROWS   = 18;

    // Mode 3 is not a legal mode, but the port allows it and the block must flag it.
    localparam logic [1:0] MODE_UNKNOWN = 2'd3;

    // How the bytes of a frame are filled before the IP header fields are written in.
    localparam logic [1:0] FILL_RANDOM = 2'd0;
    localparam logic [1:0] FILL_ZERO   = 2'd1;
    localparam logic [1:0] FILL_ONES   = 2'd2;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_frame_byte;
    logic        i_last_byte;
    logic [1:0]  i_mode;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_checksum;
    logic [15:0] o_checksum_offset;
    logic        o_frame_error;

    transport_checksum_engine dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_frame_byte      (i_frame_byte),
        .i_last_byte       (i_last_byte),
        .i_mode            (i_mode),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_checksum        (o_checksum),
        .o_checksum_offset (o_checksum_offset),
        .o_frame_error     (o_frame_error)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // One directed frame. When typed is set, the expected result is written in the row
    // itself; otherwise the local checksum model supplies it.
    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  ihl;
        logic [15:0] total;
        int          length;
        logic [1:0]  fill;
        logic        typed;
        logic [15:0] cks;
        logic [15:0] off;
        logic        err;
    } t_frame_row;

    // The first rows have results that follow directly from the frame: all-zero and
    // all-one ICMP payloads, odd-length zero padding, a short ICMP frame, frames too
    // short to reach the IP header, and the unknown mode. The rest cover header length
    // extremes, trailing padding, a bad header length, a total length below the header
    // length, segments too short to hold their checksum field, and an early end.
    t_frame_row directed_rows [0:DIRECTED_ROWS-1] = '{
        '{MODE_ICMP,    4'd0,  16'd0,     38,    FILL_ZERO,   1'b1, 16'hFFFF, 16'd36, 1'b0},
        '{MODE_ICMP,    4'd0,  16'd0,     40,    FILL_ONES,   1'b1, 16'h0000, 16'd36, 1'b0},
        '{MODE_ICMP,    4'd0,  16'd0,     39,    FILL_ONES,   1'b1, 16'h00FF, 16'd36, 1'b0},
        '{MODE_ICMP,    4'd0,  16'd0,     37,    FILL_ZERO,   1'b1, 16'hFFFF, 16'd36, 1'b1},
        '{MODE_ICMP,    4'd0,  16'd0,     1,     FILL_ONES,   1'b1, 16'hFFFF, 16'd36, 1'b1},
        '{MODE_UNKNOWN, 4'd0,  16'd0,     40,    FILL_ZERO,   1'b1, 16'hFFFF, 16'd36, 1'b1},
        '{MODE_TCP,     4'd0,  16'd0,     1,     FILL_ONES,   1'b1, 16'hFFF9, 16'd30, 1'b1},
        '{MODE_UDP,     4'd0,  16'd0,     1,     FILL_ZERO,   1'b1, 16'hFFEE, 16'd20, 1'b1},
        '{MODE_TCP,     4'd5,  16'd40,    54,    FILL_RANDOM, 1'b0, 16'h0,    16'd0,  1'b0},
        '{MODE_TCP,     4'd15, 16'd80,    100,   FILL_RANDOM, 1'b0, 16'h0,    16'd0,  1'b0},
        '{MODE_UDP,     4'd5,  16'd28,    60,    FILL_RANDOM, 1'b0, 16'h0,    16'd0,  1'b0},
        '{MODE_UDP,     4'd5,  16'd29,    43,    FILL_RANDOM, 1'b0, 16'h0,    16'd0,  1'b0},
        '{MODE_TCP,     4'd5,  16'd40,    54,    FILL_ONES,   1'b0, 16'h0,    16'd0,  1'b0},
        '{MODE_TCP,     4'd4,  16'd40,    54,    FILL_RANDOM, 1'b0, 16'h0,    16'd0,  1'b0},
        '{MODE_TCP,     4'd5,  16'd10,    60,    FILL_RANDOM, 1'b0, 16'h0,    16'd0,  1'b0},
        '{MODE_UDP,     4'd5,  16'd27,    41,    FILL_RANDOM, 1'b0, 16'h0,    16'd0,  1'b0},
        '{MODE_TCP,     4'd5,  16'd60,    50,    FILL_RANDOM, 1'b0, 16'h0,    16'd0,  1'b0},
        '{MODE_TCP,     4'd0,  16'd0,     60,    FILL_ZERO,   1'b0, 16'h0,    16'd0,  1'b0}
    };

    // Results that are still owed by the block, oldest first.
    t_result checksums_due [$];
    logic [7:0] frame_bytes [$];

    int fail_count    = 0;
    bit quiet         = 1'b0;
    bit pressure_req  = 1'b0;

    // State of the local checksum model. It mirrors the frame parser of the block:
    // position in the frame, the mode caught on the first byte, the IP header length
    // and total length fields, and the folded 16-bit running sum.
    logic [15:0] frame_pos    = '0;
    logic [1:0]  frame_mode   = '0;
    logic [3:0]  ip_ihl       = '0;
    logic [15:0] ip_total_len = '0;
    logic [15:0] running_sum  = '0;

    // Ones'-complement add; two folds are enough because both operands fit in 16 bits.
    function automatic logic [15:0] fold_add(input logic [15:0] s, input int unsigned v);
        int unsigned t;
        t = s + v;
        t = (t & 32'hFFFF) + (t >> 16);
        t = (t & 32'hFFFF) + (t >> 16);
        return 16'(t);
    endfunction

    // Words are big-endian: a byte at an even distance from the region start is the
    // high byte of its word.
    function automatic int unsigned weigh(input logic [7:0] b, input int unsigned pos,
                                          input int unsigned base);
        return ((pos ^ base) & 1) ? {8'h00, b} : {b, 8'h00};
    endfunction

    // Advances the model by one accepted byte. Returns 1 with the finished result when
    // the byte closes the frame.
    function automatic bit checksum_byte_step(input logic [7:0] b, input logic last,
                                              input logic [1:0] md, output t_result r);
        int unsigned i, hl, seg_start, seg_end, cks_rel, cks_off, seglen;
        bit transport, err;
        r = '0;
        i = frame_pos;
        if (i == 0) begin
            frame_mode   = md;
            ip_ihl       = '0;
            ip_total_len = '0;
            running_sum  = '0;
        end
        transport = (frame_mode == MODE_TCP) || (frame_mode == MODE_UDP);
        if (transport) begin
            if (i == ETH_BASE) ip_ihl = b[3:0];
            if (i == IP_LEN_HI) ip_total_len[15:8] = b;
            if (i == IP_LEN_LO) ip_total_len[7:0] = b;
        end
        hl        = 4 * ip_ihl;
        seg_start = ETH_BASE + hl;
        seg_end   = ETH_BASE + ip_total_len;
        cks_rel   = (frame_mode == MODE_TCP) ? TCP_CKS_REL : UDP_CKS_REL;
        cks_off   = transport ? seg_start + cks_rel : ICMP_CKS_OFF;

        // Bytes at the saturated position are never summed.
        if (i < INDEX_MAX) begin
            if (transport) begin
                // Source and destination addresses go into the pseudo-header.
                if (i >= ADDR_FIRST && i < ADDR_END)
                    running_sum = fold_add(running_sum, weigh(b, i, ETH_BASE));
                // The segment itself, with its checksum field read as zero and any
                // padding past the IP total length left out.
                if (i >= seg_start && i < seg_end && i != cks_off && i != cks_off + 1)
                    running_sum = fold_add(running_sum, weigh(b, i, ETH_BASE));
            end else if (i >= ICMP_BASE && i != cks_off && i != cks_off + 1) begin
                running_sum = fold_add(running_sum, weigh(b, i, ICMP_BASE));
            end
        end

        if (!last) begin
            if (frame_pos != INDEX_MAX) frame_pos = frame_pos + 1'b1;
            return 1'b0;
        end

        err = (i == INDEX_MAX);
        if (transport) begin
            // The segment length wraps when the total length is below the header length.
            seglen      = (ip_total_len - hl) & 32'hFFFF;
            running_sum = fold_add(running_sum,
                                   (frame_mode == MODE_TCP) ? PROTO_TCP : PROTO_UDP);
            running_sum = fold_add(running_sum, seglen);
            if (ip_ihl < IHL_MIN || ip_total_len < hl || seglen < cks_rel + 2 ||
                i + 1 < seg_end)
                err = 1'b1;
        end else if (frame_mode == MODE_UNKNOWN || i + 1 < ICMP_MIN_LEN) begin
            err = 1'b1;
        end
        r.checksum        = ~running_sum;
        r.checksum_offset = 16'(cks_off);
        r.frame_error     = err;
        frame_pos = '0;
        return 1'b1;
    endfunction

    // Fills frame_bytes and then writes the IHL and total length fields for the
    // TCP and UDP modes, as far as the frame reaches them.
    task automatic build_frame(input logic [1:0] md, input logic [3:0] ihl,
                               input logic [15:0] total, input int length,
                               input logic [1:0] fill);
        logic [7:0] tmp;
        frame_bytes.delete();
        for (int k = 0; k < length; k++) begin
            case (fill)
                FILL_ZERO: frame_bytes.push_back(8'h00);
                FILL_ONES: frame_bytes.push_back(8'hFF);
                default:   frame_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        if (md == MODE_TCP || md == MODE_UDP) begin
            if (length > ETH_BASE) begin
                tmp = frame_bytes[ETH_BASE];
                frame_bytes[ETH_BASE] = {tmp[7:4], ihl};
            end
            if (length > IP_LEN_HI) frame_bytes[IP_LEN_HI] = total[15:8];
            if (length > IP_LEN_LO) frame_bytes[IP_LEN_LO] = total[7:0];
        end
    endtask

    // Sends frame_bytes, one byte per transaction. The mode port carries the frame's
    // mode on the first byte and noise on every other byte, since the block must only
    // sample it at the start of a frame. About half the frames get random idle gaps.
    task automatic send_frame(input logic [1:0] md, input bit typed,
                              input t_result typed_res);
        t_result    r;
        bit         gappy;
        logic [1:0] lane_mode;
        logic       last;
        gappy = !quiet && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < frame_bytes.size(); k++) begin
            if (gappy && $urandom_range(0, 7) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            lane_mode = (k == 0) ? md : 2'($urandom_range(0, 3));
            last      = (k == frame_bytes.size() - 1);
            i_in_valid   <= 1'b1;
            i_frame_byte <= frame_bytes[k];
            i_last_byte  <= last;
            i_mode       <= lane_mode;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            // The transaction completed at this edge.
            if (checksum_byte_step(frame_bytes[k], last, lane_mode, r))
                checksums_due.push_back(typed ? typed_res : r);
        end
    endtask

    // Stimulus: reset, the directed rows, then random frames until enough bytes have
    // gone through, then a drain and the verdict.
    initial begin
        t_frame_row  row;
        t_result     typed_res;
        logic [1:0]  md;
        logic [1:0]  fill;
        logic [3:0]  ihl;
        logic [15:0] total;
        int          length;
        int          seg;
        int          pick;
        int          random_bytes;

        random_bytes  = 0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_frame_byte <= 8'h00;
        i_last_byte  <= 1'b0;
        i_mode       <= MODE_TCP;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            row = directed_rows[n];
            typed_res.checksum        = row.cks;
            typed_res.checksum_offset = row.off;
            typed_res.frame_error     = row.err;
            build_frame(row.mode, row.ihl, row.total, row.length, row.fill);
            send_frame(row.mode, row.typed, typed_res);
        end

        // The result side now holds off for a long stretch so the block backs up.
        pressure_req = 1'b1;

        // Most random frames are well-formed TCP or UDP with random content, so that
        // the segment, padding and pseudo-header paths are exercised. The rest are
        // ICMP frames around the minimum length and frames with arbitrary mode and
        // length fields.
        while (random_bytes < RANDOM_ITEMS) begin
            pick  = $urandom_range(0, 9);
            fill  = ($urandom_range(0, 15) == 0) ? FILL_ONES : FILL_RANDOM;
            ihl   = '0;
            total = '0;
            if (pick < 8) begin
                md     = ($urandom_range(0, 1) == 1) ? MODE_UDP : MODE_TCP;
                ihl    = 4'($urandom_range(5, 15));
                seg    = $urandom_range((md == MODE_TCP) ? 18 : 8, 48);
                total  = 16'(4 * ihl + seg);
                length = ETH_HEADER_BYTES + total;
                if ($urandom_range(0, 3) == 0) length += $urandom_range(1, 10);
            end else if (pick == 8) begin
                md     = MODE_ICMP;
                length = $urandom_range(30, 100);
            end else begin
                md     = 2'($urandom_range(0, 3));
                ihl    = 4'($urandom_range(0, 15));
                total  = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 150))
                                                     : 16'($urandom_range(0, 65535));
                length = $urandom_range(1, 120);
            end
            if (random_bytes >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            build_frame(md, ihl, total, length, fill);
            typed_res = '0;
            send_frame(md, 1'b0, typed_res);
            random_bytes  += length;
        end
        i_in_valid <= 1'b0;

        while (checksums_due.size() != 0) @(posedge i_clk);
        // Then wait out DRAIN_CYCLES so that any spurious result transaction is caught.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result-side stall. Stalled bursts alternate with clear windows, some of which
    // carry no stall at all. Once, the stall is held for a long stretch counted here.
    // In the quiet phase at the end no new stall burst starts.
    initial begin
        int stall_left;
        int clear_left;
        bit pressure_done;
        stall_left    = 0;
        clear_left    = 0;
        pressure_done = 1'b0;
        i_out_stall  <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0)
                stall_left--;
            else if (clear_left > 0)
                clear_left--;
            if (stall_left == 0 && clear_left == 0) begin
                clear_left = $urandom_range(1, 40);
                if (!quiet && $urandom_range(0, 2) != 0)
                    stall_left = $urandom_range(1, 19);
            end
            if (pressure_req && !pressure_done) begin
                stall_left    = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            i_out_stall <= (stall_left > 0);
        end
    end

    // Output monitor. A result transaction completes at an edge where valid is high and
    // stall is low; both are read as they stood at that edge.
    initial begin
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (checksums_due.size() == 0) begin
                    $display("%0t: unexpected result: checksum %h offset %0d error %b",
                             $time, o_checksum, o_checksum_offset, o_frame_error);
                    fail_count++;
                end else begin
                    want = checksums_due.pop_front();
                    if (o_checksum !== want.checksum) begin
                        $display("%0t: checksum mismatch: expected %h, actual %h",
                                 $time, want.checksum, o_checksum);
                        fail_count++;
                    end
                    if (o_checksum_offset !== want.checksum_offset) begin
                        $display("%0t: checksum_offset mismatch: expected %0d, actual %0d",
                                 $time, want.checksum_offset, o_checksum_offset);
                        fail_count++;
                    end
                    if (o_frame_error !== want.frame_error) begin
                        $display("%0t: frame_error mismatch: expected %b, actual %b",
                                 $time, want.frame_error, o_frame_error);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog. Allows for every byte waiting out the longest sender gap and every
    // result the longest stall, several times over.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
